FILE: hdl/assert_macros.svh
// Assertion macros used by the top RTL file of the windowed sample statistics block.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/wss_pkg.sv
// Package for the windowed sample statistics block: constants, operation and register
// codes, and the command and status bundles between controller and datapath.
`timescale 1ns / 1ps

package wss_pkg;

    localparam int DEFAULT_WINDOW_SAMPLES = 128;

    localparam int SAMPLE_W   = 32;
    localparam int AGE_W      = 7;
    localparam int OP_W       = 2;
    localparam int COUNT_OUT_W = 8;
    localparam int DAMP_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 200;

    localparam logic [DAMP_W-1:0] DAMP_ONE   = 17'd65536;
    localparam logic [DAMP_W-1:0] DAMP_RESET = 17'd62259;

    localparam logic [OP_W-1:0] OP_PUSH      = 2'd0;
    localparam logic [OP_W-1:0] OP_OVERWRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ      = 2'd2;
    localparam logic [OP_W-1:0] OP_UPDATE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DAMPENING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_KMIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_KMAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KMIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KMAX      = 3'd4;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic apply;
        logic scan_step;
        logic blend_step;
        logic div_start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic idx_last;
        logic is_update;
        logic blend_done;
        logic div_done;
    } status_t;

endpackage

FILE: hdl/windowed_sample_statistics.sv
// Windowed sample statistics: keeps the last WINDOW_SAMPLES Q16.16 samples in an on-chip
// ring with a running total, and on an update beat scans the ring for its minimum and
// maximum and blends them (or the configured limits, if enabled) into a smoothed range.
// After reset the block first clears the ring, one entry a cycle; no input beat is taken
// meanwhile, though configuration writes are. Items are handled one at a time. Push,
// overwrite and read beats pass through the bit-serial divider that forms the average;
// its length is set by TW = 33 + clog2(WINDOW_SAMPLES), the width of the running total.
// An update beat adds the window scan through the single read port of the ring and the
// blend through the shared multiplier. A finished result sits in an output register, so
// the next beat is taken while it waits.
// Depends on wss_pkg, wss_ctrl, wss_dp and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module windowed_sample_statistics #(
    parameter int WINDOW_SAMPLES = wss_pkg::DEFAULT_WINDOW_SAMPLES
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample [31:0], age [38:32]
    input  logic [wss_pkg::S_TDATA_W-1:0]      s_tdata,
    // operation [1:0]
    input  logic [wss_pkg::OP_W-1:0]           s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // read_value [31:0], average [63:32], sample_count [71:64], window_low [103:72],
    // window_high [135:104], smoothed_low [167:136], smoothed_high [199:168]
    output logic [wss_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data
);

    wss_pkg::cmd_t    cmd;
    wss_pkg::status_t st;

    assign cfg_ready = 1'b1;

    wss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    wss_dp #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .st           (st),
        .in_operation (s_tuser),
        .in_sample    (s_tdata[31:0]),
        .in_age       (s_tdata[38:32]),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_idx      (cfg_index),
        .cfg_wdata    (cfg_data),
        .out_data     (m_tdata)
    );

    // One item at a time: a taken beat closes the input until its result is formed.
    `WSS_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // A new result is never loaded over one that is still waiting.
    `WSS_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.load_out, !m_tvalid || m_tready)
    // The item is captured only on a real input beat.
    `WSS_ASSERT_SAME(a_capture_beat, aclk, aresetn, cmd.capture, s_tvalid && s_tready)

endmodule

FILE: hdl/wss_ctrl.sv
// Controller state machine of the windowed sample statistics block.
// Depends on wss_pkg; drives the datapath only through cmd_t and reads status_t.
`timescale 1ns / 1ps

module wss_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  wss_pkg::status_t st,
    output wss_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_READ   = 4'd2;
    localparam logic [3:0] S_APPLY  = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_SCANE  = 4'd5;
    localparam logic [3:0] S_BLEND  = 4'd6;
    localparam logic [3:0] S_DSTART = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (st.idx_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ: state_next = S_APPLY;
            S_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = st.is_update ? S_SCAN : S_DSTART;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (st.idx_last) begin
                    state_next = S_SCANE;
                end
            end
            S_SCANE: state_next = S_BLEND;
            S_BLEND: begin
                cmd.blend_step = 1'b1;
                if (st.blend_done) begin
                    state_next = S_DSTART;
                end
            end
            S_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (st.div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.load_out) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    assign m_tvalid = mvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

FILE: hdl/wss_dp.sv
// Datapath of the windowed sample statistics block: sample ring memory, running total,
// window scan, shared blend multiplier, restoring divider and result register. Uses wss_pkg.
`timescale 1ns / 1ps

module wss_dp #(
    parameter int WINDOW_SAMPLES = wss_pkg::DEFAULT_WINDOW_SAMPLES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wss_pkg::cmd_t                       cmd,
    output wss_pkg::status_t                    st,
    input  logic [wss_pkg::OP_W-1:0]            in_operation,
    input  logic signed [wss_pkg::SAMPLE_W-1:0] in_sample,
    input  logic [wss_pkg::AGE_W-1:0]           in_age,
    input  logic                                cfg_we,
    input  logic [wss_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [31:0]                         cfg_wdata,
    output logic [wss_pkg::M_TDATA_W-1:0]       out_data
);

    localparam int AW  = $clog2(WINDOW_SAMPLES);
    localparam int CW  = $clog2(WINDOW_SAMPLES + 1);
    localparam int TW  = wss_pkg::SAMPLE_W + AW + 1;
    localparam int DCW = $clog2(TW + 1);
    localparam int SW  = wss_pkg::SAMPLE_W;

    // Sample ring.
    logic signed [SW-1:0] ring_mem [WINDOW_SAMPLES];
    logic signed [SW-1:0] rdata_reg;
    logic [AW-1:0]        raddr;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic signed [SW-1:0] mem_wdata;

    // Window state.
    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        count_reg, count_next;
    logic signed [TW-1:0] total_reg, total_next;
    logic signed [SW-1:0] rlow_reg, rlow_next;
    logic signed [SW-1:0] rhigh_reg, rhigh_next;
    logic                 started_reg, started_next;

    // Captured item.
    logic [wss_pkg::OP_W-1:0] op_reg;
    logic signed [SW-1:0]     smp_reg;
    logic [AW-1:0]            slot_reg;
    logic                     age_ok_reg;

    // Configuration.
    logic [wss_pkg::DAMP_W-1:0] damp_reg, damp_next;
    logic                       ukmin_reg, ukmin_next;
    logic                       ukmax_reg, ukmax_next;
    logic signed [SW-1:0]       kmin_reg, kmin_next;
    logic signed [SW-1:0]       kmax_reg, kmax_next;

    // Scan and blend.
    logic                 scan_v_reg;
    logic                 first_reg;
    logic signed [SW-1:0] mn_reg, mx_reg;
    logic signed [SW-1:0] rdval_reg;
    logic [2:0]           bcnt_reg;
    logic signed [49:0]   prod_reg;
    logic signed [50:0]   acc_reg;
    logic signed [SW-1:0] win_lo, win_hi;
    logic [wss_pkg::DAMP_W-1:0] w_eff;
    logic signed [17:0]   w_old, w_new;
    logic signed [SW-1:0] mul_a;
    logic signed [17:0]   mul_b;
    logic signed [51:0]   blend_sum;
    logic signed [SW-1:0] blend_res;

    // Divider.
    logic [TW-1:0]  dq_reg;
    logic [CW-1:0]  rem_reg;
    logic [DCW-1:0] dcnt_reg;
    logic           dbusy_reg;
    logic           neg_reg;
    logic [CW:0]    rem_sh;
    logic           rem_ge;
    logic [CW:0]    rem_sub;
    logic signed [TW:0] quot;
    logic signed [SW-1:0] avg;

    logic [AW+8:0] slot_sum;
    logic          age_ok;

    assign age_ok   = 32'(in_age) < 32'(WINDOW_SAMPLES);
    // Slot of an age lies in head .. head+W-1 before wrapping, so one subtract suffices.
    assign slot_sum = (AW+9)'(head_reg) + (AW+9)'(WINDOW_SAMPLES - 1) - (AW+9)'(in_age);

    assign raddr = cmd.scan_step ? idx_reg : slot_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= ring_mem[raddr];
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = smp_reg;
        if (cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = idx_reg;
            mem_wdata = '0;
        end else if (cmd.apply) begin
            mem_we = (op_reg == wss_pkg::OP_PUSH) ||
                     (op_reg == wss_pkg::OP_OVERWRITE && age_ok_reg);
        end
    end

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        if (cmd.clr_step || cmd.scan_step) begin
            idx_next = (idx_reg == AW'(WINDOW_SAMPLES - 1)) ? '0 : idx_reg + 1'b1;
        end
        if (cmd.apply && mem_we) begin
            total_next = total_reg - TW'(rdata_reg) + TW'(smp_reg);
            if (op_reg == wss_pkg::OP_PUSH) begin
                head_next = (head_reg == AW'(WINDOW_SAMPLES - 1)) ? '0 : head_reg + 1'b1;
                if (count_reg != CW'(WINDOW_SAMPLES)) begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_comb begin
        damp_next  = damp_reg;
        ukmin_next = ukmin_reg;
        ukmax_next = ukmax_reg;
        kmin_next  = kmin_reg;
        kmax_next  = kmax_reg;
        if (cfg_we) begin
            case (cfg_idx)
                wss_pkg::CFG_DAMPENING: damp_next  = cfg_wdata[wss_pkg::DAMP_W-1:0];
                wss_pkg::CFG_USE_KMIN:  ukmin_next = cfg_wdata[0];
                wss_pkg::CFG_USE_KMAX:  ukmax_next = cfg_wdata[0];
                wss_pkg::CFG_KMIN:      kmin_next  = cfg_wdata;
                wss_pkg::CFG_KMAX:      kmax_next  = cfg_wdata;
                default: ;
            endcase
        end
    end

    // Blend: four products through one multiplier, low bound then high bound.
    assign win_lo = ukmin_reg ? kmin_reg : mn_reg;
    assign win_hi = ukmax_reg ? kmax_reg : mx_reg;
    assign w_eff  = !started_reg ? '0 :
                    (damp_reg > wss_pkg::DAMP_ONE) ? wss_pkg::DAMP_ONE : damp_reg;
    assign w_old  = 18'(w_eff);
    assign w_new  = 18'(wss_pkg::DAMP_ONE) - 18'(w_eff);

    always_comb begin
        case (bcnt_reg)
            3'd0:    begin mul_a = rlow_reg;  mul_b = w_old; end
            3'd1:    begin mul_a = win_lo;    mul_b = w_new; end
            3'd2:    begin mul_a = rhigh_reg; mul_b = w_old; end
            default: begin mul_a = win_hi;    mul_b = w_new; end
        endcase
    end

    assign blend_sum = 52'(acc_reg) + 52'(prod_reg) + 52'sd32768;
    assign blend_res = SW'(blend_sum >>> 16);

    always_comb begin
        rlow_next    = rlow_reg;
        rhigh_next   = rhigh_reg;
        started_next = started_reg;
        if (cmd.blend_step && bcnt_reg == 3'd2) begin
            rlow_next = blend_res;
        end
        if (cmd.blend_step && bcnt_reg == 3'd4) begin
            rhigh_next   = blend_res;
            started_next = 1'b1;
        end
    end

    // Restoring division of the total magnitude by the count, one bit a cycle.
    assign rem_sh  = {rem_reg, dq_reg[TW-1]};
    assign rem_ge  = rem_sh >= {1'b0, count_reg};
    assign rem_sub = rem_sh - {1'b0, count_reg};
    assign quot    = neg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});

    always_comb begin
        if (count_reg == '0) begin
            avg = '0;
        end else if (quot > (TW+1)'(32'sh7FFFFFFF)) begin
            avg = 32'sh7FFFFFFF;
        end else if (quot < -(TW+1)'(33'sh080000000)) begin
            avg = 32'sh80000000;
        end else begin
            avg = SW'(quot);
        end
    end

    assign st.idx_last   = idx_reg == AW'(WINDOW_SAMPLES - 1);
    assign st.is_update  = op_reg == wss_pkg::OP_UPDATE;
    assign st.blend_done = cmd.blend_step && bcnt_reg == 3'd4;
    assign st.div_done   = dbusy_reg && dcnt_reg == DCW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            idx_reg     <= '0;
            count_reg   <= '0;
            total_reg   <= '0;
            rlow_reg    <= '0;
            rhigh_reg   <= '0;
            started_reg <= 1'b0;
            damp_reg    <= wss_pkg::DAMP_RESET;
            ukmin_reg   <= 1'b0;
            ukmax_reg   <= 1'b0;
            kmin_reg    <= '0;
            kmax_reg    <= '0;
            scan_v_reg  <= 1'b0;
            bcnt_reg    <= '0;
            dbusy_reg   <= 1'b0;
            dcnt_reg    <= '0;
        end else begin
            head_reg    <= head_next;
            idx_reg     <= idx_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            rlow_reg    <= rlow_next;
            rhigh_reg   <= rhigh_next;
            started_reg <= started_next;
            damp_reg    <= damp_next;
            ukmin_reg   <= ukmin_next;
            ukmax_reg   <= ukmax_next;
            kmin_reg    <= kmin_next;
            kmax_reg    <= kmax_next;
            scan_v_reg  <= cmd.scan_step;
            if (cmd.blend_step) begin
                bcnt_reg <= (bcnt_reg == 3'd4) ? 3'd0 : bcnt_reg + 3'd1;
            end
            if (cmd.div_start) begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= DCW'(TW);
            end else if (dbusy_reg) begin
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == DCW'(1)) begin
                    dbusy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= in_operation;
            smp_reg    <= in_sample;
            age_ok_reg <= age_ok;
            if (in_operation == wss_pkg::OP_PUSH) begin
                slot_reg <= head_reg;
            end else if (slot_sum >= (AW+9)'(WINDOW_SAMPLES)) begin
                slot_reg <= AW'(slot_sum - (AW+9)'(WINDOW_SAMPLES));
            end else begin
                slot_reg <= AW'(slot_sum);
            end
        end
        if (cmd.apply) begin
            rdval_reg <= (op_reg == wss_pkg::OP_READ && age_ok_reg) ? rdata_reg : '0;
            first_reg <= 1'b1;
        end
        if (scan_v_reg) begin
            first_reg <= 1'b0;
            if (first_reg || rdata_reg < mn_reg) begin
                mn_reg <= rdata_reg;
            end
            if (first_reg || rdata_reg > mx_reg) begin
                mx_reg <= rdata_reg;
            end
        end
        if (cmd.blend_step) begin
            prod_reg <= mul_a * mul_b;
            if (bcnt_reg == 3'd1 || bcnt_reg == 3'd3) begin
                acc_reg <= 51'(prod_reg);
            end
        end
        if (cmd.div_start) begin
            neg_reg <= total_reg[TW-1];
            dq_reg  <= total_reg[TW-1] ? TW'(-total_reg) : TW'(total_reg);
            rem_reg <= '0;
        end else if (dbusy_reg) begin
            dq_reg  <= {dq_reg[TW-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
        end
        if (cmd.load_out) begin
            out_data[31:0]    <= rdval_reg;
            out_data[63:32]   <= avg;
            out_data[71:64]   <= wss_pkg::COUNT_OUT_W'(count_reg);
            out_data[103:72]  <= st.is_update ? win_lo : '0;
            out_data[135:104] <= st.is_update ? win_hi : '0;
            out_data[167:136] <= rlow_reg;
            out_data[199:168] <= rhigh_reg;
        end
    end

endmodule

FILE: verif/tb_top.sv
// Self-checking bench for windowed_sample_statistics: a directed table, then random beats.
// Results are predicted by an in-bench model of the sample ring and range smoothing.
// Depends on wss_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;

    localparam int WIN = wss_pkg::DEFAULT_WINDOW_SAMPLES;
    localparam int CYCLE_LIMIT = 1000000;

    // Declared from the top bit down, so read_value lands in the lowest bits of m_tdata.
    typedef struct packed {
        logic [31:0] smoothed_high;
        logic [31:0] smoothed_low;
        logic [31:0] window_high;
        logic [31:0] window_low;
        logic [7:0]  sample_count;
        logic [31:0] average;
        logic [31:0] read_value;
    } stats_t;

    typedef struct {
        logic [wss_pkg::OP_W-1:0] op;
        logic [31:0]              smp;
        logic [6:0]               age;
        bit                       has_fixed;
        stats_t                   fixed;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [wss_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [wss_pkg::OP_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [wss_pkg::M_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [wss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    windowed_sample_statistics dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predictor state.
    logic signed [31:0] ring [WIN];
    int unsigned head;
    longint total;
    int unsigned filled;
    logic signed [31:0] rng_lo, rng_hi;
    bit started;
    int unsigned damp;
    bit kmin_en, kmax_en;
    logic signed [31:0] kmin, kmax;

    stats_t pending_stats[$];
    int errors = 0;
    int checked = 0;
    int cycles = 0;
    bit long_hold = 1'b0;

    function automatic logic signed [31:0] smooth(logic signed [31:0] old_v,
                                                  logic signed [31:0] raw, int unsigned w);
        longint s;
        s = longint'(old_v) * longint'(w) + longint'(raw) * longint'(65536 - w) + 32768;
        return 32'(s >>> 16);
    endfunction

    function automatic stats_t predict_stats(logic [wss_pkg::OP_W-1:0] op,
                                             logic signed [31:0] smp, int unsigned age);
        stats_t r;
        int unsigned slot;
        int unsigned w;
        logic signed [31:0] mn, mx;
        longint q;
        r = '0;
        slot = (head + WIN - 1 - age) % WIN;
        case (op)
            wss_pkg::OP_PUSH: begin
                total = total - ring[head] + smp;
                ring[head] = smp;
                head = (head + 1) % WIN;
                if (filled < WIN) filled++;
            end
            wss_pkg::OP_OVERWRITE: begin
                if (age < WIN) begin
                    total = total - ring[slot] + smp;
                    ring[slot] = smp;
                end
            end
            wss_pkg::OP_READ: begin
                if (age < WIN) r.read_value = ring[slot];
            end
            default: begin
                mn = ring[0];
                mx = ring[0];
                for (int i = 1; i < WIN; i++) begin
                    if (ring[i] < mn) mn = ring[i];
                    if (ring[i] > mx) mx = ring[i];
                end
                r.window_low = kmin_en ? kmin : mn;
                r.window_high = kmax_en ? kmax : mx;
                if (started) begin
                    w = (damp > 65536) ? 65536 : damp;
                end else begin
                    w = 0;
                    started = 1'b1;
                end
                rng_lo = smooth(rng_lo, r.window_low, w);
                rng_hi = smooth(rng_hi, r.window_high, w);
            end
        endcase
        if (filled != 0) begin
            q = total / longint'(filled);
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            r.average = 32'(q);
        end
        r.sample_count = 8'(filled);
        r.smoothed_low = rng_lo;
        r.smoothed_high = rng_hi;
        return r;
    endfunction

    task automatic write_reg(logic [wss_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            wss_pkg::CFG_DAMPENING: damp = val[16:0];
            wss_pkg::CFG_USE_KMIN:  kmin_en = val[0];
            wss_pkg::CFG_USE_KMAX:  kmax_en = val[0];
            wss_pkg::CFG_KMIN:      kmin = val;
            wss_pkg::CFG_KMAX:      kmax = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 2) == 0) n = 0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic send_beat(logic [wss_pkg::OP_W-1:0] op, logic [31:0] smp,
                             logic [6:0] age, bit gaps);
        if (gaps) idle_gap();
        s_tuser <= op;
        s_tdata <= {1'b0, age, smp};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
        pending_stats.push_back(predict_stats(op, smp, age));
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending_stats.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 8000)) - 4000) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    // Result checker; the receiver stalls at random, with one long hold-off.
    always @(posedge aclk) begin
        stats_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_stats.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result beat: %h", got);
            end else begin
                want = pending_stats.pop_front();
                checked++;
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("Mismatch at result %0d", checked);
                        $display("  expected rv=%h avg=%h cnt=%h wl=%h wh=%h sl=%h sh=%h",
                                 want.read_value, want.average, want.sample_count,
                                 want.window_low, want.window_high,
                                 want.smoothed_low, want.smoothed_high);
                        $display("  actual   rv=%h avg=%h cnt=%h wl=%h wh=%h sl=%h sh=%h",
                                 got.read_value, got.average, got.sample_count,
                                 got.window_low, got.window_high,
                                 got.smoothed_low, got.smoothed_high);
                    end
                end
            end
        end
    end

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                hold = 3000;
                long_hold = 1'b0;
            end else if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 19) == 0) begin
                m_tready <= 1'b0;
                hold = $urandom_range(1, 80);
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    row_t dir_rows[$];

    function automatic row_t mk(logic [wss_pkg::OP_W-1:0] op, logic [31:0] smp,
                                logic [6:0] age);
        row_t r;
        r.op = op;
        r.smp = smp;
        r.age = age;
        r.has_fixed = 1'b0;
        r.fixed = '0;
        return r;
    endfunction

    initial begin
        row_t r;
        stats_t want;
        logic [wss_pkg::OP_W-1:0] op;
        int nres;
        bit gaps;
        for (int i = 0; i < WIN; i++) ring[i] = '0;
        head = 0; total = 0; filled = 0;
        rng_lo = '0; rng_hi = '0; started = 1'b0;
        damp = 32'(wss_pkg::DAMP_RESET);
        kmin_en = 1'b0; kmax_en = 1'b0; kmin = '0; kmax = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table; the first rows after reset have results readable at a glance.
        r = mk(wss_pkg::OP_READ, 32'h0, 7'd0);
        r.has_fixed = 1'b1;
        dir_rows.push_back(r);
        r = mk(wss_pkg::OP_UPDATE, 32'h0, 7'd0);
        r.has_fixed = 1'b1;
        dir_rows.push_back(r);
        dir_rows.push_back(mk(wss_pkg::OP_PUSH, 32'h7fffffff, 7'd0));
        dir_rows.push_back(mk(wss_pkg::OP_PUSH, 32'h80000000, 7'd0));
        dir_rows.push_back(mk(wss_pkg::OP_PUSH, 32'h00010000, 7'd0));
        dir_rows.push_back(mk(wss_pkg::OP_READ, 32'h0, 7'd1));
        dir_rows.push_back(mk(wss_pkg::OP_READ, 32'h0, 7'd127));
        dir_rows.push_back(mk(wss_pkg::OP_UPDATE, 32'h0, 7'd0));
        // Overwrites of slots never pushed drive the average beyond 32 bits.
        for (int i = 3; i < 9; i++) begin
            dir_rows.push_back(mk(wss_pkg::OP_OVERWRITE, 32'h7fffffff, 7'(i)));
        end
        dir_rows.push_back(mk(wss_pkg::OP_READ, 32'h0, 7'd5));
        for (int i = 3; i < 9; i++) begin
            dir_rows.push_back(mk(wss_pkg::OP_OVERWRITE, 32'h80000000, 7'(i)));
        end
        dir_rows.push_back(mk(wss_pkg::OP_OVERWRITE, 32'hffff0000, 7'd127));
        dir_rows.push_back(mk(wss_pkg::OP_UPDATE, 32'h0, 7'd0));
        dir_rows.push_back(mk(wss_pkg::OP_READ, 32'h0, 7'd0));

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            send_beat(r.op, r.smp, r.age, 1'b1);
            if (r.has_fixed) begin
                // Everything is zero straight after reset.
                want = '0;
                if (pending_stats[$] != want) begin
                    errors++;
                    $display("Predictor disagrees with directed row %0d", i);
                end
            end
        end
        drain();

        // Phases over register settings, extremes among them.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(wss_pkg::CFG_DAMPENING, 32'd0);
                    write_reg(wss_pkg::CFG_USE_KMIN, 32'd1);
                    write_reg(wss_pkg::CFG_KMIN, 32'h80000000);
                end
                1: begin
                    write_reg(wss_pkg::CFG_DAMPENING, 32'd65536);
                    write_reg(wss_pkg::CFG_USE_KMAX, 32'd1);
                    write_reg(wss_pkg::CFG_KMAX, 32'h7fffffff);
                end
                2: begin
                    write_reg(wss_pkg::CFG_DAMPENING, 32'h1ffff);
                    write_reg(wss_pkg::CFG_KMIN, 32'h7fffffff);
                    write_reg(wss_pkg::CFG_KMAX, 32'h80000000);
                end
                3: begin
                    write_reg(wss_pkg::CFG_USE_KMIN, 32'd0);
                    write_reg(wss_pkg::CFG_USE_KMAX, 32'd0);
                    write_reg(wss_pkg::CFG_DAMPENING, $urandom_range(0, 65536));
                    write_reg(3'd7, $urandom);
                end
                4: begin
                    write_reg(wss_pkg::CFG_DAMPENING, 32'd62259);
                    write_reg(wss_pkg::CFG_USE_KMIN, 32'd1);
                    write_reg(wss_pkg::CFG_KMIN, $urandom);
                    write_reg(wss_pkg::CFG_KMAX, $urandom);
                end
                default: begin
                    write_reg(wss_pkg::CFG_USE_KMAX, 32'd1);
                    write_reg(wss_pkg::CFG_DAMPENING, $urandom_range(1, 65535));
                end
            endcase
            nres = 65;
            if (ph == 2) long_hold = 1'b1;
            for (int k = 0; k < nres; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: op = wss_pkg::OP_PUSH;
                    4, 5: op = wss_pkg::OP_OVERWRITE;
                    6, 7: op = wss_pkg::OP_READ;
                    default: op = wss_pkg::OP_UPDATE;
                endcase
                gaps = (ph != 2) && ($urandom_range(0, 4) != 0);
                send_beat(op, rand_sample(), 7'($urandom), gaps);
            end
            drain();
        end

        $display("Checked %0d result beats over a directed table and six register settings.",
                 checked);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches in total", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
